// ===== rtl/gls_pkg.sv =====
// Shared types, codes and helpers for the grid line-of-sight block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package gls_pkg;

	localparam int ROW_W  = 6;
	localparam int MAPW_W = 7;

	localparam logic              CMD_WRITE     = 1'b0;
	localparam logic              CMD_QUERY     = 1'b1;
	localparam logic [MAPW_W-1:0] MAP_WIDTH_RST = 7'd40;

	// segment end cells of a query
	typedef struct packed {
		logic [ROW_W-1:0] ra;
		logic [ROW_W-1:0] ca;
		logic [ROW_W-1:0] rb;
		logic [ROW_W-1:0] cb;
	} seg_t;

	// change of the cross product per cell step, doubled coordinates
	typedef logic signed [ROW_W+2:0] step_t;

	// one column further: +2*dx, dx = 2*(rb-ra)
	function automatic step_t step_col(input seg_t s);
		logic signed [ROW_W:0] d;
		d = $signed({1'b0, s.rb}) - $signed({1'b0, s.ra});
		return {d, 2'b00};
	endfunction

	// one row further: -2*dy, dy = 2*(cb-ca)
	function automatic step_t step_row(input seg_t s);
		logic signed [ROW_W:0] d;
		d = $signed({1'b0, s.ca}) - $signed({1'b0, s.cb});
		return {d, 2'b00};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gls_ifs.sv =====
// Handshake interfaces for the grid line-of-sight block: item, result, config.
// Depends on gls_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gls_item_if;
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [gls_pkg::ROW_W-1:0] row_a;
	logic [gls_pkg::ROW_W-1:0] col_a;
	logic [gls_pkg::ROW_W-1:0] row_b;
	logic [gls_pkg::ROW_W-1:0] col_b;
	logic                     wall_flag;

	modport source (output valid, command, row_a, col_a, row_b, col_b, wall_flag,
		input ready);
	modport sink (input valid, command, row_a, col_a, row_b, col_b, wall_flag,
		output ready);
endinterface

interface gls_result_if;
	logic valid;
	logic ready;
	logic path_clear;

	modport source (output valid, path_clear, input ready);
	modport sink (input valid, path_clear, output ready);
endinterface

interface gls_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [gls_pkg::MAPW_W-1:0] map_width;

	modport source (output valid, map_width, input ready);
	modport sink (input valid, map_width, output ready);
endinterface

`default_nettype wire

// ===== rtl/grid_line_of_sight.sv =====
// Grid line-of-sight block: wall map store, scan sequencer and edge test unit.
// Depends on gls_pkg, gls_ifs, gls_wall_ram and gls_edge_unit.
//
// Channels: item (sink) carries write and query commands, result (source) carries
// one path_clear beat per query, cfg (sink) writes map_width at any time, always
// ready, and is meant to be written only while the block is idle.
// A write beat gives no result; writes may follow each other
// in consecutive cycles.
// A query, n = min(map_width, GRID_SIDE): the shared multiplier in ST_MUL0 and
// ST_MUL1 and a load of the difference in ST_INIT set up the corner cross product, then
// the scan reads one cell a cycle from the wall store and the edge unit checks all its
// edges; ST_DRAIN drains the read and ST_FIN loads the result register.
// A zero-length segment or n of zero goes straight to ST_FIN. item.ready is low
// throughout.
// After reset the store is swept to open, one cell a cycle over all
// 2**(2*clog2(GRID_SIDE)) cells (4096 at the default), with item.ready low.
// The result register holds a beat until taken; writes are accepted meanwhile,
// and a finished query waits for the register to free up.
`timescale 1ns / 1ps
`default_nettype none

module grid_line_of_sight #(
	parameter int GRID_SIDE = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	gls_item_if.sink     item,
	gls_result_if.source result,
	gls_cfg_if.sink      cfg
);
	import gls_pkg::*;

	localparam int IDX_W = $clog2(GRID_SIDE);
	localparam int AW    = 2 * IDX_W;
	localparam int NW    = (IDX_W + 1 > MAPW_W) ? IDX_W + 1 : MAPW_W;
	localparam int CW    = ((IDX_W > ROW_W) ? IDX_W : ROW_W) + 2;
	localparam int FW    = CW + 9;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MUL0  = 3'd2;
	localparam logic [2:0] ST_MUL1  = 3'd3;
	localparam logic [2:0] ST_INIT  = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]           state_q;
	logic [MAPW_W-1:0]    map_width_q;
	logic [AW-1:0]        clr_q;
	seg_t                 seg_q;
	logic [IDX_W-1:0]     nm1_q, i_q, j_q, i_s1, j_s1;
	logic signed [FW-1:0] cur_q, row_q, f_s1;
	logic signed [15:0]   prod_q, f0_q;
	logic                 v_s1, blocked_q, res_valid_q, path_clear_q;

	logic                 in_acc, wr_acc, qry_acc, res_free, hit, rd_bit;
	logic [NW-1:0]        n_eff;
	logic [NW-1:0]        nm1_w;
	logic signed [7:0]    mul_a, mul_b;
	logic signed [15:0]   prod;
	logic                 we, wdata;
	logic [AW-1:0]        waddr;
	step_t                st_c, st_r;
	logic signed [FW-1:0] f_init, row_nx;

	assign item.ready  = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign in_acc      = item.valid && item.ready;
	assign wr_acc      = in_acc && (item.command == CMD_WRITE);
	assign qry_acc     = in_acc && (item.command == CMD_QUERY);
	assign res_free    = !res_valid_q || result.ready;

	assign result.valid      = res_valid_q;
	assign result.path_clear = path_clear_q;

	assign n_eff = (NW'(map_width_q) > NW'(GRID_SIDE)) ? NW'(GRID_SIDE) : NW'(map_width_q);
	assign nm1_w = n_eff - NW'(1);

	// shared multiplier: dy*(1+px), then dx*(1+py)
	always_comb begin
		if (state_q == ST_MUL0) begin
			mul_a = $signed({1'b0, seg_q.cb, 1'b0}) - $signed({1'b0, seg_q.ca, 1'b0});
			mul_b = $signed({1'b0, seg_q.ra, 1'b1});
		end else begin
			mul_a = $signed({1'b0, seg_q.rb, 1'b0}) - $signed({1'b0, seg_q.ra, 1'b0});
			mul_b = $signed({1'b0, seg_q.ca, 1'b1});
		end
	end
	assign prod = mul_a * mul_b;

	assign st_c   = step_col(seg_q);
	assign st_r   = step_row(seg_q);
	assign f_init = FW'(f0_q) - FW'(prod_q);
	assign row_nx = row_q + FW'(st_r);

	// store write port: clearing sweep or a write beat inside the grid
	always_comb begin
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = 1'b0;
		end else begin
			we    = wr_acc && (NW'(item.row_a) < NW'(GRID_SIDE))
				&& (NW'(item.col_a) < NW'(GRID_SIDE));
			waddr = {IDX_W'(item.row_a), IDX_W'(item.col_a)};
			wdata = item.wall_flag;
		end
	end

	gls_wall_ram #(
		.AW(AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (state_q == ST_SCAN),
		.raddr({i_q, j_q}),
		.rdata(rd_bit)
	);

	gls_edge_unit #(
		.IDX_W(IDX_W),
		.FW   (FW)
	) u_edge (
		.seg (seg_q),
		.row (i_s1),
		.col (j_s1),
		.f_a (f_s1),
		.wall(rd_bit),
		.hit (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			map_width_q <= MAP_WIDTH_RST;
			clr_q       <= '0;
			v_s1        <= 1'b0;
			blocked_q   <= 1'b0;
			res_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			nm1_q       <= '0;
			prod_q      <= '0;
			f0_q        <= '0;
			cur_q       <= '0;
			row_q       <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				map_width_q <= cfg.map_width;
			end
			if ((state_q == ST_FIN) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			v_s1 <= (state_q == ST_SCAN);
			if (v_s1 && hit) begin
				blocked_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (qry_acc) begin
						blocked_q <= 1'b0;
						i_q       <= '0;
						j_q       <= '0;
						nm1_q     <= nm1_w[IDX_W-1:0];
						if (((item.row_a == item.row_b) && (item.col_a == item.col_b))
							|| (n_eff == '0)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL0;
						end
					end
				end
				ST_MUL0: begin
					prod_q  <= prod;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					f0_q    <= prod_q;
					prod_q  <= prod;
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					cur_q   <= f_init;
					row_q   <= f_init;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q == nm1_q) begin
						j_q <= '0;
						if (i_q == nm1_q) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q   <= i_q + IDX_W'(1);
							row_q <= row_nx;
							cur_q <= row_nx;
						end
					end else begin
						j_q   <= j_q + IDX_W'(1);
						cur_q <= cur_q + FW'(st_c);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (qry_acc) begin
			seg_q <= '{ra: item.row_a, ca: item.col_a, rb: item.row_b, cb: item.col_b};
		end
		if (state_q == ST_SCAN) begin
			i_s1 <= i_q;
			j_s1 <= j_q;
			f_s1 <= cur_q;
		end
		if ((state_q == ST_FIN) && res_free) begin
			path_clear_q <= !blocked_q;
		end
	end

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		qry_acc |=> !item.ready)
		else $error("item ready straight after a query beat");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finish step");

	a_block_from_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(blocked_q) |-> $past(v_s1 && hit))
		else $error("blocked flag set without an edge hit");

endmodule

`default_nettype wire

// ===== rtl/gls_wall_ram.sv =====
// One-bit wall map store, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gls_wall_ram #(
	parameter int AW = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata
);

	logic mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gls_edge_unit.sv =====
// Tests the segment against each edge of a cell, combinationally.
// Depends on gls_pkg; corner cross product supplied by the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module gls_edge_unit #(
	parameter int IDX_W = 6,
	parameter int FW    = 17
) (
	input  wire gls_pkg::seg_t      seg,
	input  wire logic [IDX_W-1:0]   row,
	input  wire logic [IDX_W-1:0]   col,
	input  wire logic signed [FW-1:0] f_a,
	input  wire logic               wall,
	output logic                    hit
);
	import gls_pkg::*;

	localparam int CMPW = (IDX_W > ROW_W) ? IDX_W : ROW_W;

	step_t                st_c, st_r;
	logic signed [FW-1:0] f_b, f_c, f_d;
	logic [CMPW-1:0]      i_w, j_w, ra_w, ca_w, rb_w, cb_w;
	logic                 e_lo_y, e_hi_y, e_lo_x, e_hi_x;

	function automatic logic span(input logic signed [FW-1:0] a,
		input logic signed [FW-1:0] b);
		logic pa, pb;
		pa = !a[FW-1] && (|a);
		pb = !b[FW-1] && (|b);
		return !(pa && pb) && !(a[FW-1] && b[FW-1]);
	endfunction

	always_comb begin
		st_c = step_col(seg);
		st_r = step_row(seg);
		// corners: a=(lo,lo) b=(hi,lo) c=(lo,hi) d=(hi,hi) in (row,col)
		f_b  = f_a + FW'(st_r);
		f_c  = f_a + FW'(st_c);
		f_d  = f_c + FW'(st_r);
		i_w  = CMPW'(row);
		j_w  = CMPW'(col);
		ra_w = CMPW'(seg.ra);
		ca_w = CMPW'(seg.ca);
		rb_w = CMPW'(seg.rb);
		cb_w = CMPW'(seg.cb);
		// centres are even, edges odd: straddle reduces to index compares
		e_lo_y = ((ca_w < j_w) != (cb_w < j_w)) && span(f_a, f_b);
		e_hi_y = ((ca_w <= j_w) != (cb_w <= j_w)) && span(f_c, f_d);
		e_lo_x = ((ra_w < i_w) != (rb_w < i_w)) && span(f_a, f_c);
		e_hi_x = ((ra_w <= i_w) != (rb_w <= i_w)) && span(f_b, f_d);
		hit    = wall && (e_lo_y || e_hi_y || e_lo_x || e_hi_x);
	end

endmodule

`default_nettype wire

// ===== bench/grid_line_of_sight_tb.sv =====
// Self-checking bench for grid_line_of_sight: wall writes and line-of-sight queries,
// predicted in doubled integer coordinates and checked beat by beat.
// Depends on gls_pkg, gls_ifs and the grid_line_of_sight RTL.
`timescale 1ns / 1ps

module grid_line_of_sight_tb;

	import gls_pkg::*;

	localparam int SIDE       = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam int TAIL_WAIT  = 4200;

	typedef struct {
		logic             command;
		logic [ROW_W-1:0] row_a;
		logic [ROW_W-1:0] col_a;
		logic [ROW_W-1:0] row_b;
		logic [ROW_W-1:0] col_b;
		logic             wall_flag;
	} grid_cmd_t;

	logic clk;
	logic arst_n;

	gls_item_if   item_if ();
	gls_result_if result_if ();
	gls_cfg_if    cfg_if ();

	grid_line_of_sight #(.GRID_SIDE(SIDE)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	bit              wall_map [0:SIDE-1][0:SIDE-1];
	logic [MAPW_W-1:0] map_width_now;
	bit              pending_clear [$];
	int              max_gap;
	int              mismatches;
	int              writes_sent;
	int              queries_sent;
	int              widths_set;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int cross_sign(int ax, int ay, int bx, int by, int cx, int cy);
		int v;
		v = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
		if (v > 0)
			return 1;
		if (v < 0)
			return -1;
		return 0;
	endfunction

	function automatic bit spans_overlap(int a, int b, int c, int d);
		int lo1, hi1, lo2, hi2;
		lo1 = a < b ? a : b;
		hi1 = a < b ? b : a;
		lo2 = c < d ? c : d;
		hi2 = c < d ? d : c;
		return lo1 <= hi2 && lo2 <= hi1;
	endfunction

	// inclusive: segments PQ and UV share at least one point
	function automatic bit segs_touch(int px, int py, int qx, int qy,
			int ux, int uy, int vx, int vy);
		int o1, o2, o3, o4;
		o1 = cross_sign(px, py, qx, qy, ux, uy);
		o2 = cross_sign(px, py, qx, qy, vx, vy);
		o3 = cross_sign(ux, uy, vx, vy, px, py);
		o4 = cross_sign(ux, uy, vx, vy, qx, qy);
		if (o1 == 0 && o2 == 0)
			return spans_overlap(px, qx, ux, vx) && spans_overlap(py, qy, uy, vy);
		return o1 * o2 <= 0 && o3 * o4 <= 0;
	endfunction

	function automatic bit sight_clear(logic [ROW_W-1:0] ra, logic [ROW_W-1:0] ca,
			logic [ROW_W-1:0] rb, logic [ROW_W-1:0] cb);
		int n, px, py, qx, qy, lx, hx, ly, hy;
		n  = map_width_now > SIDE ? SIDE : int'(map_width_now);
		px = 2 * int'(ra);
		py = 2 * int'(ca);
		qx = 2 * int'(rb);
		qy = 2 * int'(cb);
		if (px == qx && py == qy)
			return 1'b1;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				if (wall_map[i][j]) begin
					lx = 2 * i - 1;
					hx = 2 * i + 1;
					ly = 2 * j - 1;
					hy = 2 * j + 1;
					if (segs_touch(px, py, qx, qy, lx, ly, hx, ly) ||
							segs_touch(px, py, qx, qy, lx, hy, hx, hy) ||
							segs_touch(px, py, qx, qy, lx, ly, lx, hy) ||
							segs_touch(px, py, qx, qy, hx, ly, hx, hy))
						return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	// appends one expected path_clear beat
	function automatic void queue_expected(input bit v);
		pending_clear.insert(pending_clear.size(), v);
	endfunction

	// ------------------------------------------------------------ item builders

	function automatic grid_cmd_t wall_write(int r, int c, bit flag);
		grid_cmd_t w;
		w.command   = CMD_WRITE;
		w.row_a     = ROW_W'(r);
		w.col_a     = ROW_W'(c);
		w.row_b     = ROW_W'($urandom_range(0, SIDE - 1));
		w.col_b     = ROW_W'($urandom_range(0, SIDE - 1));
		w.wall_flag = flag;
		return w;
	endfunction

	function automatic grid_cmd_t sight_query(int ra, int ca, int rb, int cb);
		grid_cmd_t q;
		q.command   = CMD_QUERY;
		q.row_a     = ROW_W'(ra);
		q.col_a     = ROW_W'(ca);
		q.row_b     = ROW_W'(rb);
		q.col_b     = ROW_W'(cb);
		q.wall_flag = 1'($urandom_range(0, 1));
		return q;
	endfunction

	// mostly inside the active area or just past its edge, sometimes anywhere
	function automatic int pick_coord(int n);
		int span;
		span = n < 1 ? 1 : (n > SIDE - 1 ? SIDE - 1 : n);
		if ($urandom_range(0, 99) < 15)
			return $urandom_range(0, SIDE - 1);
		return $urandom_range(0, span);
	endfunction

	function automatic grid_cmd_t random_cmd(int n);
		int ra, ca;
		ra = pick_coord(n);
		ca = pick_coord(n);
		if ($urandom_range(0, 99) < 40)
			return wall_write(ra, ca, $urandom_range(0, 99) < 70);
		if ($urandom_range(0, 99) < 10)
			return sight_query(ra, ca, ra, ca);
		return sight_query(ra, ca, pick_coord(n), pick_coord(n));
	endfunction

	// ------------------------------------------------------------------ drivers

	task automatic send_cmd(input grid_cmd_t c);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			@(negedge clk);
			item_if.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_if.valid     = 1'b1;
		item_if.command   = c.command;
		item_if.row_a     = c.row_a;
		item_if.col_a     = c.col_a;
		item_if.row_b     = c.row_b;
		item_if.col_b     = c.col_b;
		item_if.wall_flag = c.wall_flag;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		if (c.command == CMD_WRITE) begin
			wall_map[c.row_a][c.col_a] = c.wall_flag;
			writes_sent++;
		end else begin
			queue_expected(sight_clear(c.row_a, c.col_a, c.row_b, c.col_b));
			queries_sent++;
		end
	endtask

	// hold off until every query has answered and the last write has landed
	task automatic settle();
		@(negedge clk);
		item_if.valid = 1'b0;
		while (pending_clear.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_map_width(input int w);
		settle();
		@(negedge clk);
		cfg_if.valid     = 1'b1;
		cfg_if.map_width = MAPW_W'(w);
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		map_width_now = MAPW_W'(w);
		widths_set++;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// receiver: random stall before each result beat
	initial begin
		int stall;
		forever begin
			stall = $urandom_range(0, max_gap);
			if (stall > 0) begin
				@(negedge clk);
				result_if.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			result_if.ready = 1'b1;
			@(posedge clk);
			while (!result_if.valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (result_if.valid && result_if.ready) begin
			if (pending_clear.size() == 0) begin
				$error("path_clear beat with no query outstanding: actual %0b",
					result_if.path_clear);
				mismatches++;
			end else if (result_if.path_clear !== pending_clear[0]) begin
				$error("path_clear mismatch: expected %0b actual %0b",
					pending_clear[0], result_if.path_clear);
				mismatches++;
				void'(pending_clear.pop_front());
			end else begin
				void'(pending_clear.pop_front());
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
		$display("grid_line_of_sight verification failed");
		$finish;
	end

	// -------------------------------------------------------------------- tests

	task automatic test_basic_geometry();
		send_cmd(sight_query(0, 0, 0, 0));
		send_cmd(sight_query(0, 0, 63, 63));
		send_cmd(wall_write(5, 5, 1'b1));
		send_cmd(sight_query(5, 0, 5, 10));
		send_cmd(sight_query(3, 0, 3, 10));
		send_cmd(sight_query(4, 5, 6, 7));   // grazes one corner only
		send_cmd(sight_query(5, 5, 5, 6));   // starts inside a wall
		send_cmd(sight_query(5, 5, 5, 5));
		send_cmd(wall_write(5, 5, 1'b0));
		send_cmd(sight_query(5, 0, 5, 10));
		send_cmd(wall_write(63, 63, 1'b1));
		send_cmd(sight_query(62, 62, 63, 63)); // wall outside active area
	endtask

	task automatic test_width_limits();
		set_map_width(SIDE);
		send_cmd(sight_query(62, 62, 63, 63));
		set_map_width(127);
		send_cmd(sight_query(63, 63, 0, 0));
		set_map_width(0);
		send_cmd(sight_query(0, 0, 63, 63));
		set_map_width(1);
		send_cmd(wall_write(0, 0, 1'b1));
		send_cmd(sight_query(0, 2, 2, 0));
		send_cmd(sight_query(0, 0, 0, 1));
		send_cmd(sight_query(1, 1, 0, 0));
		send_cmd(wall_write(0, 0, 1'b0));
		send_cmd(wall_write(63, 63, 1'b0));
		send_cmd(sight_query(1, 1, 0, 0));
	endtask

	task automatic test_random_traffic();
		int widths [8];
		int counts [8];
		widths = '{8, 16, 4, 64, 12, 1, 127, 24};
		counts = '{20, 20, 15, 8, 20, 10, 6, 20};
		for (int p = 0; p < 8; p++) begin
			set_map_width(widths[p]);
			max_gap = (p == 2 || p == 4) ? 0 : 10;
			for (int k = 0; k < counts[p]; k++) begin
				if (p == 1 && k == counts[p] / 2)
					settle();
				send_cmd(random_cmd(widths[p] > SIDE ? SIDE : widths[p]));
			end
		end
		max_gap = 10;
	endtask

	initial begin
		arst_n            = 1'b0;
		item_if.valid     = 1'b0;
		item_if.command   = CMD_WRITE;
		item_if.row_a     = '0;
		item_if.col_a     = '0;
		item_if.row_b     = '0;
		item_if.col_b     = '0;
		item_if.wall_flag = 1'b0;
		result_if.ready   = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.map_width  = '0;
		map_width_now     = MAP_WIDTH_RST;
		max_gap           = 10;
		mismatches        = 0;
		writes_sent       = 0;
		queries_sent      = 0;
		widths_set        = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_geometry();
		test_width_limits();
		test_random_traffic();

		settle();
		repeat (TAIL_WAIT) @(posedge clk);
		$display("covered %0d wall writes and %0d line-of-sight queries over %0d width writes",
			writes_sent, queries_sent, widths_set);
		$display("incl. corner grazes, zero-length segments, width 0, 1, 64 and 127");
		if (mismatches == 0)
			$display("grid_line_of_sight verification clean");
		else
			$display("grid_line_of_sight verification failed");
		$finish;
	end

endmodule
